// ===== rtl/ldpm_pkg.sv =====
// Shared types, constants and arithmetic helpers for the lens distortion point map.
// Used by ldpm_div and by the lens_distortion_point_map top level; no dependencies.
package ldpm_pkg;

  localparam int DATA_W         = 24;
  localparam int CFG_IDX_W      = 3;
  localparam int NORM_FRAC      = 24;
  localparam int NORM_INT       = 3;
  localparam int Q_W            = NORM_FRAC + NORM_INT;
  localparam int DIV_LAT        = Q_W + 3;
  localparam int COEF_FRAC_DEF  = 20;
  localparam logic [DATA_W-1:0] FOCAL_RST = 24'd256;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FOCAL_X,
    REG_FOCAL_Y,
    REG_CENTER_X,
    REG_CENTER_Y,
    REG_RADIAL_K1,
    REG_RADIAL_K2,
    REG_TANG_P1,
    REG_TANG_P2
  } cfg_reg_t;

  // Divides by 2^n and rounds half away from zero.
  function automatic logic signed [63:0] rnd64(input logic signed [63:0] v,
                                               input int unsigned n);
    logic signed [63:0] h;
    logic signed [63:0] s;
    h = 64'sd1 <<< (n - 1);
    s = v + h - {{63{1'b0}}, v[63]};
    return s >>> n;
  endfunction

  // True when v is representable as a b-bit signed value.
  function automatic logic fits64(input logic signed [63:0] v, input int unsigned b);
    logic signed [63:0] t;
    t = v >>> (b - 1);
    return (t == '0) || (t == '1);
  endfunction

endpackage

// ===== rtl/ldpm_div.sv =====
// Pipelined restoring divider that normalizes one coordinate offset by a focal length.
// One quotient bit per stage; depends on ldpm_pkg.
module ldpm_div (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_vld,
  input  logic signed [ldpm_pkg::DATA_W:0]  in_d,
  input  logic [ldpm_pkg::DATA_W-1:0]       focal,
  output logic                              out_vld,
  output logic signed [ldpm_pkg::Q_W:0]     out_q,
  output logic                              out_flag
);
  import ldpm_pkg::*;

  localparam int D_W = DATA_W + 1;
  localparam int N_W = D_W + NORM_FRAC;

  logic [DATA_W-1:0] fu;
  logic [D_W-1:0]    mag;

  logic              vld0_r;
  logic              neg0_r;
  logic [N_W-1:0]    n0_r;

  logic              st_vld_r [Q_W+1];
  logic              st_neg_r [Q_W+1];
  logic              st_big_r [Q_W+1];
  logic [DATA_W-1:0] st_rem_r [Q_W+1];
  logic [Q_W-1:0]    st_low_r [Q_W+1];
  logic [Q_W-1:0]    st_q_r   [Q_W+1];

  logic                 out_vld_r;
  logic signed [Q_W:0]  out_q_r;
  logic                 out_flag_r;

  assign fu  = (focal == '0) ? DATA_W'(1) : focal;
  assign mag = in_d[D_W-1] ? D_W'(-in_d) : D_W'(in_d);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld0_r <= 1'b0;
    end else begin
      vld0_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    neg0_r <= in_d[D_W-1];
    n0_r   <= {mag, {NORM_FRAC{1'b0}}} + N_W'(fu[DATA_W-1:1]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_vld_r[0] <= 1'b0;
    end else begin
      st_vld_r[0] <= vld0_r;
    end
  end

  always_ff @(posedge clk) begin
    st_neg_r[0] <= neg0_r;
    st_big_r[0] <= {2'b00, n0_r} >= {fu, {Q_W{1'b0}}};
    st_rem_r[0] <= DATA_W'(n0_r[N_W-1:Q_W]);
    st_low_r[0] <= n0_r[Q_W-1:0];
    st_q_r[0]   <= '0;
  end

  for (genvar k = 0; k < Q_W; k++) begin : g_stage
    logic [DATA_W:0] t;
    logic            ge;
    assign t  = {st_rem_r[k], st_low_r[k][Q_W-1-k]};
    assign ge = t >= {1'b0, fu};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        st_vld_r[k+1] <= 1'b0;
      end else begin
        st_vld_r[k+1] <= st_vld_r[k];
      end
    end

    always_ff @(posedge clk) begin
      st_neg_r[k+1] <= st_neg_r[k];
      st_big_r[k+1] <= st_big_r[k];
      st_rem_r[k+1] <= ge ? DATA_W'(t - {1'b0, fu}) : t[DATA_W-1:0];
      st_low_r[k+1] <= st_low_r[k];
      st_q_r[k+1]   <= {st_q_r[k][Q_W-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= st_vld_r[Q_W];
    end
  end

  always_ff @(posedge clk) begin
    if (st_neg_r[Q_W]) begin
      out_flag_r <= 1'b0;
      out_q_r    <= st_big_r[Q_W] ? {1'b1, {Q_W{1'b0}}}
                                  : (Q_W+1)'(-$signed({1'b0, st_q_r[Q_W]}));
    end else begin
      out_flag_r <= st_big_r[Q_W];
      out_q_r    <= st_big_r[Q_W] ? {1'b0, {Q_W{1'b1}}} : $signed({1'b0, st_q_r[Q_W]});
    end
  end

  assign out_vld  = out_vld_r;
  assign out_q    = out_q_r;
  assign out_flag = out_flag_r;

endmodule

// ===== rtl/lens_distortion_point_map.sv =====
// Lens distortion point map: accepts one item per cycle and returns each result with out_strobe.
// The pipeline never stalls and busy stays low; an item passes through one input register, the
// divider pipelines that normalize each coordinate and 20 multiply and round stages.
// Reset (rst_n low at a clock edge) empties the pipeline and restores register defaults.
// Depends on ldpm_pkg and ldpm_div.
module lens_distortion_point_map #(
  parameter int COEF_FRAC_BITS = ldpm_pkg::COEF_FRAC_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   start,
  output logic                                   busy,
  input  logic signed [ldpm_pkg::DATA_W-1:0]     in_undist_col,
  input  logic signed [ldpm_pkg::DATA_W-1:0]     in_undist_row,
  output logic                                   out_strobe,
  output logic signed [ldpm_pkg::DATA_W-1:0]     out_dist_col,
  output logic signed [ldpm_pkg::DATA_W-1:0]     out_dist_row,
  output logic                                   out_clipped,
  input  logic                                   cfg_we,
  input  logic [ldpm_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [ldpm_pkg::DATA_W-1:0]            cfg_data
);
  import ldpm_pkg::*;

  localparam int NSTG    = 20;
  localparam int LATENCY = DIV_LAT + NSTG + 1;
  localparam int WIDE_W  = 36;
  localparam logic signed [52:0] ONE_NORM = 53'sd1 <<< NORM_FRAC;
  localparam logic signed [WIDE_W-1:0] WIDE_MAX = {1'b0, {(WIDE_W-1){1'b1}}};
  localparam logic signed [WIDE_W-1:0] WIDE_MIN = {1'b1, {(WIDE_W-1){1'b0}}};
  localparam logic signed [DATA_W-1:0] OUT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic signed [DATA_W-1:0] OUT_MIN = {1'b1, {(DATA_W-1){1'b0}}};
  localparam logic signed [Q_W:0] NORM_MAX = {1'b0, {Q_W{1'b1}}};

  logic [DATA_W-1:0]        focal_x_r, focal_y_r;
  logic signed [DATA_W-1:0] center_x_r, center_y_r;
  logic signed [DATA_W-1:0] radial_k1_r, radial_k2_r, tang_p1_r, tang_p2_r;

  logic                     a_vld_r;
  logic signed [DATA_W:0]   a_d_r [2];

  logic                     dv_vld [2];
  logic signed [Q_W:0]      dq     [2];
  logic                     dflag  [2];

  logic [NSTG-1:0]          vld_r;

  logic signed [55:0] s1_sq_r [2];
  logic signed [55:0] s1_xy_r;
  logic signed [Q_W:0] s1_x_r [2];
  logic s1_flag_r;

  logic signed [31:0] s2_sq_r [2];
  logic signed [31:0] s2_xy_r;
  logic signed [Q_W:0] s2_x_r [2];
  logic s2_flag_r;

  logic signed [32:0] s3_r2_r;
  logic signed [34:0] s3_ta_r [2];
  logic signed [32:0] s3_xy2_r;
  logic signed [Q_W:0] s3_x_r [2];
  logic s3_flag_r;

  logic signed [63:0] s4_r4p_r;
  logic signed [56:0] s4_k1p_r;
  logic signed [58:0] s4_tp1_r [2];
  logic signed [58:0] s4_tp2_r [2];
  logic signed [Q_W:0] s4_x_r [2];
  logic s4_flag_r;

  logic signed [39:0] s5_r4_r;
  logic signed [47:0] s5_k1_r;
  logic signed [47:0] s5_tp1_r [2];
  logic signed [47:0] s5_tp2_r [2];
  logic signed [Q_W:0] s5_x_r [2];
  logic s5_flag_r;

  logic signed [44:0] s6_k2lo_r;
  logic signed [43:0] s6_k2hi_r;
  logic signed [47:0] s6_k1_r;
  logic signed [47:0] s6_tp1_r [2];
  logic signed [47:0] s6_tp2_r [2];
  logic signed [Q_W:0] s6_x_r [2];
  logic s6_flag_r;

  logic signed [63:0] s7_k2p_r;
  logic signed [47:0] s7_k1_r;
  logic signed [47:0] s7_tp1_r [2];
  logic signed [47:0] s7_tp2_r [2];
  logic signed [Q_W:0] s7_x_r [2];
  logic s7_flag_r;

  logic signed [51:0] s8_k2_r;
  logic signed [47:0] s8_k1_r;
  logic signed [48:0] s8_ts_r [2];
  logic signed [Q_W:0] s8_x_r [2];
  logic s8_flag_r;

  logic signed [52:0] s9_kc_r;
  logic signed [48:0] s9_ts_r [2];
  logic signed [Q_W:0] s9_x_r [2];
  logic s9_flag_r;

  logic signed [WIDE_W-1:0] s10_kc_r;
  logic signed [48:0] s10_ts_r [2];
  logic signed [Q_W:0] s10_x_r [2];
  logic s10_flag_r;

  logic signed [46:0] s11_lo_r [2];
  logic signed [45:0] s11_hi_r [2];
  logic signed [48:0] s11_ts_r [2];
  logic s11_flag_r;

  logic signed [63:0] s12_xk_r [2];
  logic signed [48:0] s12_ts_r [2];
  logic s12_flag_r;

  logic signed [39:0] s13_xk_r [2];
  logic signed [48:0] s13_ts_r [2];
  logic s13_flag_r;

  logic signed [49:0] s14_d_r [2];
  logic s14_flag_r;

  logic signed [WIDE_W-1:0] s15_d_r [2];
  logic s15_flag_r;

  logic signed [43:0] s16_lo_r [2];
  logic signed [42:0] s16_hi_r [2];
  logic s16_flag_r;

  logic signed [63:0] s17_p_r [2];
  logic s17_flag_r;

  logic signed [36:0] s18_p_r [2];
  logic s18_flag_r;

  logic signed [37:0] s19_o_r [2];
  logic s19_flag_r;

  logic signed [DATA_W-1:0] dist_col_r, dist_row_r;
  logic                     clipped_r;

  logic                     kc_ovf;
  logic signed [WIDE_W-1:0] kc_sat;
  logic                     d_ovf [2];
  logic signed [WIDE_W-1:0] d_sat [2];
  logic                     o_ovf [2];
  logic signed [DATA_W-1:0] o_sat [2];
  logic [DATA_W-1:0]        focal_l  [2];
  logic signed [DATA_W-1:0] center_l [2];

  assign busy = 1'b0;
  assign focal_l[0]  = focal_x_r;
  assign focal_l[1]  = focal_y_r;
  assign center_l[0] = center_x_r;
  assign center_l[1] = center_y_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      focal_x_r   <= FOCAL_RST;
      focal_y_r   <= FOCAL_RST;
      center_x_r  <= '0;
      center_y_r  <= '0;
      radial_k1_r <= '0;
      radial_k2_r <= '0;
      tang_p1_r   <= '0;
      tang_p2_r   <= '0;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_FOCAL_X:   focal_x_r   <= cfg_data;
        REG_FOCAL_Y:   focal_y_r   <= cfg_data;
        REG_CENTER_X:  center_x_r  <= $signed(cfg_data);
        REG_CENTER_Y:  center_y_r  <= $signed(cfg_data);
        REG_RADIAL_K1: radial_k1_r <= $signed(cfg_data);
        REG_RADIAL_K2: radial_k2_r <= $signed(cfg_data);
        REG_TANG_P1:   tang_p1_r   <= $signed(cfg_data);
        REG_TANG_P2:   tang_p2_r   <= $signed(cfg_data);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
      vld_r   <= '0;
    end else begin
      a_vld_r <= start & ~busy;
      vld_r   <= {vld_r[NSTG-2:0], dv_vld[0]};
    end
  end

  always_ff @(posedge clk) begin
    a_d_r[0] <= (DATA_W+1)'(in_undist_col) - (DATA_W+1)'(center_x_r);
    a_d_r[1] <= (DATA_W+1)'(in_undist_row) - (DATA_W+1)'(center_y_r);
  end

  ldpm_div u_div_x (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (a_vld_r),
    .in_d     (a_d_r[0]),
    .focal    (focal_x_r),
    .out_vld  (dv_vld[0]),
    .out_q    (dq[0]),
    .out_flag (dflag[0])
  );

  ldpm_div u_div_y (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (a_vld_r),
    .in_d     (a_d_r[1]),
    .focal    (focal_y_r),
    .out_vld  (dv_vld[1]),
    .out_q    (dq[1]),
    .out_flag (dflag[1])
  );

  always_comb begin
    kc_ovf = !fits64(64'(s9_kc_r), WIDE_W);
    kc_sat = kc_ovf ? (s9_kc_r[52] ? WIDE_MIN : WIDE_MAX) : s9_kc_r[WIDE_W-1:0];
    for (int l = 0; l < 2; l++) begin
      d_ovf[l] = !fits64(64'(s14_d_r[l]), WIDE_W);
      d_sat[l] = d_ovf[l] ? (s14_d_r[l][49] ? WIDE_MIN : WIDE_MAX)
                          : s14_d_r[l][WIDE_W-1:0];
      o_ovf[l] = !fits64(64'(s19_o_r[l]), DATA_W);
      o_sat[l] = o_ovf[l] ? (s19_o_r[l][37] ? OUT_MIN : OUT_MAX)
                          : s19_o_r[l][DATA_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    s1_xy_r   <= dq[0] * dq[1];
    s1_flag_r <= dflag[0] | dflag[1];
    s2_xy_r   <= 32'(rnd64(64'(s1_xy_r), NORM_FRAC));
    s2_flag_r <= s1_flag_r;
    s3_r2_r   <= 33'(s2_sq_r[0]) + 33'(s2_sq_r[1]);
    s3_xy2_r  <= 33'(s2_xy_r) <<< 1;
    s3_ta_r[0] <= (35'(s2_sq_r[0]) <<< 1) + 35'(s2_sq_r[0]) + 35'(s2_sq_r[1]);
    s3_ta_r[1] <= (35'(s2_sq_r[1]) <<< 1) + 35'(s2_sq_r[1]) + 35'(s2_sq_r[0]);
    s3_flag_r <= s2_flag_r;
    s4_r4p_r  <= s3_r2_r * s3_r2_r;
    s4_k1p_r  <= radial_k1_r * s3_r2_r;
    s4_tp1_r[0] <= tang_p1_r * s3_xy2_r;
    s4_tp2_r[0] <= tang_p2_r * s3_ta_r[0];
    s4_tp1_r[1] <= tang_p1_r * s3_ta_r[1];
    s4_tp2_r[1] <= tang_p2_r * s3_xy2_r;
    s4_flag_r <= s3_flag_r;
    s5_r4_r   <= 40'(rnd64(s4_r4p_r, NORM_FRAC));
    s5_k1_r   <= 48'(rnd64(64'(s4_k1p_r), COEF_FRAC_BITS));
    s5_flag_r <= s4_flag_r;
    s6_k2lo_r <= radial_k2_r * $signed({1'b0, s5_r4_r[19:0]});
    s6_k2hi_r <= radial_k2_r * $signed(s5_r4_r[39:20]);
    s6_k1_r   <= s5_k1_r;
    s6_flag_r <= s5_flag_r;
    s7_k2p_r  <= (64'(s6_k2hi_r) <<< 20) + 64'(s6_k2lo_r);
    s7_k1_r   <= s6_k1_r;
    s7_flag_r <= s6_flag_r;
    s8_k2_r   <= 52'(rnd64(s7_k2p_r, COEF_FRAC_BITS));
    s8_k1_r   <= s7_k1_r;
    s8_flag_r <= s7_flag_r;
    s9_kc_r   <= ONE_NORM + 53'(s8_k1_r) + 53'(s8_k2_r);
    s9_flag_r <= s8_flag_r;
    s10_kc_r   <= kc_sat;
    s10_flag_r <= s9_flag_r | kc_ovf;
    s11_flag_r <= s10_flag_r;
    s12_flag_r <= s11_flag_r;
    s13_flag_r <= s12_flag_r;
    s14_flag_r <= s13_flag_r;
    s15_flag_r <= s14_flag_r | d_ovf[0] | d_ovf[1];
    s16_flag_r <= s15_flag_r;
    s17_flag_r <= s16_flag_r;
    s18_flag_r <= s17_flag_r;
    s19_flag_r <= s18_flag_r;
    clipped_r  <= s19_flag_r | o_ovf[0] | o_ovf[1];
    dist_col_r <= o_sat[0];
    dist_row_r <= o_sat[1];

    for (int l = 0; l < 2; l++) begin
      s1_sq_r[l]  <= dq[l] * dq[l];
      s1_x_r[l]   <= dq[l];
      s2_sq_r[l]  <= 32'(rnd64(64'(s1_sq_r[l]), NORM_FRAC));
      s2_x_r[l]   <= s1_x_r[l];
      s3_x_r[l]   <= s2_x_r[l];
      s4_x_r[l]   <= s3_x_r[l];
      s5_tp1_r[l] <= 48'(rnd64(64'(s4_tp1_r[l]), COEF_FRAC_BITS));
      s5_tp2_r[l] <= 48'(rnd64(64'(s4_tp2_r[l]), COEF_FRAC_BITS));
      s5_x_r[l]   <= s4_x_r[l];
      s6_tp1_r[l] <= s5_tp1_r[l];
      s6_tp2_r[l] <= s5_tp2_r[l];
      s6_x_r[l]   <= s5_x_r[l];
      s7_tp1_r[l] <= s6_tp1_r[l];
      s7_tp2_r[l] <= s6_tp2_r[l];
      s7_x_r[l]   <= s6_x_r[l];
      s8_ts_r[l]  <= 49'(s7_tp1_r[l]) + 49'(s7_tp2_r[l]);
      s8_x_r[l]   <= s7_x_r[l];
      s9_ts_r[l]  <= s8_ts_r[l];
      s9_x_r[l]   <= s8_x_r[l];
      s10_ts_r[l] <= s9_ts_r[l];
      s10_x_r[l]  <= s9_x_r[l];
      s11_lo_r[l] <= s10_x_r[l] * $signed({1'b0, s10_kc_r[17:0]});
      s11_hi_r[l] <= s10_x_r[l] * $signed(s10_kc_r[WIDE_W-1:18]);
      s11_ts_r[l] <= s10_ts_r[l];
      s12_xk_r[l] <= (64'(s11_hi_r[l]) <<< 18) + 64'(s11_lo_r[l]);
      s12_ts_r[l] <= s11_ts_r[l];
      s13_xk_r[l] <= 40'(rnd64(s12_xk_r[l], NORM_FRAC));
      s13_ts_r[l] <= s12_ts_r[l];
      s14_d_r[l]  <= 50'(s13_xk_r[l]) + 50'(s13_ts_r[l]);
      s15_d_r[l]  <= d_sat[l];
      s16_lo_r[l] <= $signed({1'b0, s15_d_r[l][17:0]}) * $signed({1'b0, focal_l[l]});
      s16_hi_r[l] <= $signed(s15_d_r[l][WIDE_W-1:18]) * $signed({1'b0, focal_l[l]});
      s17_p_r[l]  <= (64'(s16_hi_r[l]) <<< 18) + 64'(s16_lo_r[l]);
      s18_p_r[l]  <= 37'(rnd64(s17_p_r[l], NORM_FRAC));
      s19_o_r[l]  <= 38'(s18_p_r[l]) + 38'(center_l[l]);
    end
  end

  assign out_strobe   = vld_r[NSTG-1];
  assign out_dist_col = dist_col_r;
  assign out_dist_row = dist_row_r;
  assign out_clipped  = clipped_r;

`ifndef NO_ASSERTIONS
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(start, LATENCY))
    else $error("result strobe without a matching accepted item");

  a_lanes_aligned: assert property (@(posedge clk) disable iff (!rst_n)
    dv_vld[0] == dv_vld[1])
    else $error("divider lanes out of step");

  a_norm_clip: assert property (@(posedge clk) disable iff (!rst_n)
    (dv_vld[0] && dflag[0]) |-> (dq[0] == NORM_MAX))
    else $error("normalized column flagged but not saturated");
`endif

endmodule

// ===== tb/sv/ldpm_checker.sv =====
// Checker for the lens distortion point map: tracks register writes, predicts each result
// from the accepted item and compares it with the output strobe. Depends on ldpm_pkg.
`timescale 1ns / 100ps
module ldpm_checker (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic                              busy,
  input  logic signed [ldpm_pkg::DATA_W-1:0] in_undist_col,
  input  logic signed [ldpm_pkg::DATA_W-1:0] in_undist_row,
  input  logic                              out_strobe,
  input  logic signed [ldpm_pkg::DATA_W-1:0] out_dist_col,
  input  logic signed [ldpm_pkg::DATA_W-1:0] out_dist_row,
  input  logic                              out_clipped,
  input  logic                              cfg_we,
  input  logic [ldpm_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [ldpm_pkg::DATA_W-1:0]       cfg_data,
  output int                                fail_count,
  output int                                pending,
  output int                                mapped_count,
  output int                                clip_count
);
  import ldpm_pkg::*;

  typedef struct {
    logic signed [23:0] col;
    logic signed [23:0] row;
    logic               clip;
  } point_t;

  localparam int CF = 20;
  localparam longint NLIM = 64'sd1 <<< 27;
  localparam longint WLIM = 64'sd1 <<< 35;
  localparam longint OLIM = 64'sd1 <<< 23;

  logic [23:0] regs [8];
  point_t expected_points[$];

  function automatic longint round_shift(longint v, int n);
    longint m;
    m = v < 0 ? -v : v;
    m = (m + (64'sd1 <<< (n - 1))) >>> n;
    return v < 0 ? -m : m;
  endfunction

  function automatic longint clamp(longint v, longint lim, ref logic flag);
    if (v < -lim) begin
      flag = 1'b1;
      return -lim;
    end
    if (v > lim - 1) begin
      flag = 1'b1;
      return lim - 1;
    end
    return v;
  endfunction

  function automatic longint to_norm(longint d, logic [23:0] f, ref logic flag);
    longint fu;
    longint m;
    fu = (f == 0) ? 1 : longint'(f);
    m = d < 0 ? -d : d;
    m = ((m <<< 24) + (fu >>> 1)) / fu;
    if (m > NLIM) m = NLIM;
    return clamp(d < 0 ? -m : m, NLIM, flag);
  endfunction

  function automatic point_t map_point(logic signed [23:0] c, logic signed [23:0] r);
    point_t p;
    logic flag;
    longint cx, cy, k1, k2, p1, p2, x, y, x2, y2, xy, r2, r4, kc, xd, yd;
    flag = 1'b0;
    cx = longint'($signed(regs[REG_CENTER_X]));
    cy = longint'($signed(regs[REG_CENTER_Y]));
    k1 = longint'($signed(regs[REG_RADIAL_K1]));
    k2 = longint'($signed(regs[REG_RADIAL_K2]));
    p1 = longint'($signed(regs[REG_TANG_P1]));
    p2 = longint'($signed(regs[REG_TANG_P2]));
    x = to_norm(longint'(c) - cx, regs[REG_FOCAL_X], flag);
    y = to_norm(longint'(r) - cy, regs[REG_FOCAL_Y], flag);
    x2 = round_shift(x * x, 24);
    y2 = round_shift(y * y, 24);
    xy = round_shift(x * y, 24);
    r2 = x2 + y2;
    r4 = round_shift(r2 * r2, 24);
    kc = (64'sd1 <<< 24) + round_shift(k1 * r2, CF) + round_shift(k2 * r4, CF);
    kc = clamp(kc, WLIM, flag);
    xd = round_shift(x * kc, 24) + round_shift(p1 * (2 * xy), CF)
         + round_shift(p2 * (r2 + 2 * x2), CF);
    yd = round_shift(y * kc, 24) + round_shift(p1 * (r2 + 2 * y2), CF)
         + round_shift(p2 * (2 * xy), CF);
    xd = clamp(xd, WLIM, flag);
    yd = clamp(yd, WLIM, flag);
    p.col = 24'(clamp(round_shift(xd * longint'(regs[REG_FOCAL_X]), 24) + cx, OLIM, flag));
    p.row = 24'(clamp(round_shift(yd * longint'(regs[REG_FOCAL_Y]), 24) + cy, OLIM, flag));
    p.clip = flag;
    return p;
  endfunction

  assign pending = expected_points.size();

  always @(posedge clk) begin
    point_t e;
    if (!rst_n) begin
      regs <= '{24'd256, 24'd256, 24'd0, 24'd0, 24'd0, 24'd0, 24'd0, 24'd0};
      expected_points.delete();
      fail_count <= 0;
      mapped_count <= 0;
      clip_count <= 0;
    end else begin
      if (cfg_we) begin
        regs[cfg_index] <= cfg_data;
      end
      if (start && !busy) begin
        expected_points.push_back(map_point(in_undist_col, in_undist_row));
      end
      if (out_strobe) begin
        mapped_count <= mapped_count + 1;
        if (out_clipped) clip_count <= clip_count + 1;
        if (expected_points.size() == 0) begin
          $error("unexpected result col=%0d row=%0d", out_dist_col, out_dist_row);
          fail_count <= fail_count + 1;
        end else begin
          e = expected_points.pop_front();
          if (out_dist_col !== e.col || out_dist_row !== e.row || out_clipped !== e.clip) begin
            if (out_dist_col !== e.col)
              $error("dist_col expected %0d got %0d", e.col, out_dist_col);
            if (out_dist_row !== e.row)
              $error("dist_row expected %0d got %0d", e.row, out_dist_row);
            if (out_clipped !== e.clip)
              $error("clipped expected %0b got %0b", e.clip, out_clipped);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end
endmodule

// ===== tb/sv/testbench.sv =====
// Stimulus and verdict for the lens distortion point map: register settings, directed and
// random points. Depends on ldpm_pkg, ldpm_checker and lens_distortion_point_map.
`timescale 1ns / 100ps
module testbench;
  import ldpm_pkg::*;

  localparam int LATENCY = 51;
  localparam int WATCHDOG = 4000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic signed [23:0] in_undist_col = '0;
  logic signed [23:0] in_undist_row = '0;
  logic out_strobe;
  logic signed [23:0] out_dist_col;
  logic signed [23:0] out_dist_row;
  logic out_clipped;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [23:0] cfg_data = '0;
  int fail_count, pending, mapped_count, clip_count;
  int quiet_cycles = 0;
  int gap_pct = 0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  lens_distortion_point_map i_dut (.*);

  ldpm_checker i_checker (.*);

  always @(posedge clk) begin
    if ((start && !busy) || out_strobe) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG) begin
      $display("watchdog expired with %0d results outstanding", pending);
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic write_reg(cfg_reg_t idx, logic [23:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic drain();
    while (pending != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  task automatic send_point(logic signed [23:0] c, logic signed [23:0] r);
    @(posedge clk);
    while ($urandom_range(99) < gap_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    in_undist_col <= c;
    in_undist_row <= r;
    @(posedge clk iff 1'b1);
    while (busy) @(posedge clk);
    start <= 1'b0;
  endtask

  task automatic send_stream(int n, int spread);
    int i;
    logic signed [23:0] c, r;
    for (i = 0; i < n; i++) begin
      while ($urandom_range(99) < gap_pct) begin
        start <= 1'b0;
        @(posedge clk);
      end
      if ($urandom_range(9) == 0) begin
        c = 24'($urandom);
        r = 24'($urandom);
      end else begin
        c = 24'($signed($urandom_range(2 * spread)) - spread);
        r = 24'($signed($urandom_range(2 * spread)) - spread);
      end
      start <= 1'b1;
      in_undist_col <= c;
      in_undist_row <= r;
      while (1) begin
        @(posedge clk);
        if (!busy) break;
      end
    end
    start <= 1'b0;
  endtask

  task automatic random_config();
    write_reg(REG_FOCAL_X, 24'($urandom_range(256 * 4000, 256 * 100)));
    write_reg(REG_FOCAL_Y, 24'($urandom_range(256 * 4000, 256 * 100)));
    write_reg(REG_CENTER_X, 24'($urandom_range(256 * 2000)));
    write_reg(REG_CENTER_Y, 24'($urandom_range(256 * 2000)));
    write_reg(REG_RADIAL_K1, 24'($signed($urandom_range(600000)) - 300000));
    write_reg(REG_RADIAL_K2, 24'($signed($urandom_range(200000)) - 100000));
    write_reg(REG_TANG_P1, 24'($signed($urandom_range(20000)) - 10000));
    write_reg(REG_TANG_P2, 24'($signed($urandom_range(20000)) - 10000));
  endtask

  initial begin
    int phase;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Directed points at reset settings, then at the register extremes.
    send_point(24'sh7FFFFF, 24'sh7FFFFF);
    send_point(-24'sh800000, -24'sh800000);
    send_point(24'sd0, 24'sd0);
    send_point(24'sd256, -24'sd256);
    send_point(24'sd1, -24'sd1);
    drain();
    write_reg(REG_FOCAL_X, 24'd0);
    write_reg(REG_FOCAL_Y, 24'hFFFFFF);
    write_reg(REG_CENTER_X, 24'h800000);
    write_reg(REG_CENTER_Y, 24'h7FFFFF);
    write_reg(REG_RADIAL_K1, 24'h7FFFFF);
    write_reg(REG_RADIAL_K2, 24'h7FFFFF);
    write_reg(REG_TANG_P1, 24'h800000);
    write_reg(REG_TANG_P2, 24'h7FFFFF);
    send_point(24'sh7FFFFF, -24'sh800000);
    send_point(-24'sh800000, 24'sh7FFFFF);
    send_point(24'sd0, 24'sd0);
    send_point(24'sd12345, -24'sd999);
    drain();
    write_reg(REG_FOCAL_X, 24'd256);
    write_reg(REG_FOCAL_Y, 24'd256);
    write_reg(REG_RADIAL_K1, 24'h800000);
    write_reg(REG_RADIAL_K2, 24'h800000);
    write_reg(REG_TANG_P1, 24'h7FFFFF);
    write_reg(REG_TANG_P2, 24'h800000);
    write_reg(REG_CENTER_X, 24'd0);
    write_reg(REG_CENTER_Y, 24'd0);
    send_point(24'sd300, 24'sd300);
    send_point(-24'sd512, 24'sd100);
    send_point(24'sh7FFFFF, 24'sd0);
    send_point(24'sd0, -24'sh800000);
    drain();

    for (phase = 0; phase < 9; phase++) begin
      gap_pct = (phase < 3) ? 24 : (phase < 6) ? 48 : 0;
      random_config();
      send_stream(125, (phase % 3 == 0) ? 256 * 8000 : 256 * 3000);
      drain();
    end

    $display("Mapped %0d points over several register settings; %0d were clipped.",
             mapped_count, clip_count);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule
